// ===== rtl/dcrb_pkg.sv =====
`timescale 1ns / 1ps
package dcrb_pkg;

	localparam int NUM_CHANNELS_DEF = 16;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT1,
		ST_OUT2
	} state_t;

	// word offsets inside a channel block
	localparam logic [3:0] RG_SRC0   = 4'h0;
	localparam logic [3:0] RG_DST0   = 4'h1;
	localparam logic [3:0] RG_CNT0   = 4'h2;
	localparam logic [3:0] RG_SRC1   = 4'h3;
	localparam logic [3:0] RG_DST1   = 4'h4;
	localparam logic [3:0] RG_CNT1   = 4'h5;
	localparam logic [3:0] RG_CURSRC = 4'h6;
	localparam logic [3:0] RG_CURDST = 4'h7;
	localparam logic [3:0] RG_CURCNT = 4'h8;
	localparam logic [3:0] RG_STATUS = 4'h9;
	localparam logic [3:0] RG_CTRL   = 4'ha;
	localparam logic [3:0] RG_CONFIG = 4'hb;
	localparam logic [3:0] RG_INTVL  = 4'hc;
	localparam logic [3:0] RG_EXT    = 4'hd;
	localparam logic [3:0] RG_LINK   = 4'he;
	localparam logic [3:0] RG_CURLNK = 4'hf;

	// word index (address bits 9:2) of group words
	localparam logic [7:0] GW_CTRL = 8'hc0;
	localparam logic [7:0] GW_EN   = 8'hc4;
	localparam logic [7:0] GW_ER   = 8'hc5;
	localparam logic [7:0] GW_END  = 8'hc6;
	localparam logic [7:0] GW_TC   = 8'hc7;

	localparam logic [31:0] CFG_CH4_RESET = 32'h0020026c;
	localparam int CFG_SAD_BIT = 20;
	localparam int CFG_DAD_BIT = 21;
	localparam int CFG_DEM_BIT = 24;
	localparam int CFG_RSW_BIT = 29;
	localparam int CFG_REN_BIT = 30;

	localparam logic [6:0] ST_EN   = 7'h01;
	localparam logic [6:0] ST_TACT = 7'h04;
	localparam logic [6:0] ST_ER   = 7'h10;
	localparam logic [6:0] ST_END  = 7'h20;
	localparam logic [6:0] ST_TC   = 7'h40;

	localparam int CT_SETEN  = 0;
	localparam int CT_CLREN  = 1;
	localparam int CT_SWRST  = 3;
	localparam int CT_CLREND = 5;
	localparam int CT_CLRTC  = 6;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sel2;
	} cmd_t;

	typedef struct packed {
		logic two;
	} sts_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_pulse;
		logic [3:0]  irq_channel;
		logic        xfer_valid;
		logic [31:0] xfer_source;
		logic [31:0] xfer_dest;
		logic [31:0] xfer_bytes;
		logic        src_fixed;
		logic        dst_fixed;
		logic [5:0]  unit_bytes;
		logic        last;
	} result_t;

	// smaller of source and destination unit, 1 above 32 bytes
	function automatic logic [5:0] unit_size(input logic [31:0] cfg);
		logic [3:0] e;
		begin
			e = (cfg[15:12] < cfg[19:16]) ? cfg[15:12] : cfg[19:16];
			unit_size = (e > 4'd5) ? 6'd1 : (6'd1 << e[2:0]);
		end
	endfunction

endpackage

// ===== rtl/dcrb_req_if.sv =====
`timescale 1ns / 1ps
interface dcrb_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [10:0] address;
	logic [2:0]  access_bytes;
	logic [31:0] write_data;

	modport source (output valid, req_type, address, access_bytes, write_data, input ready);
	modport sink (input valid, req_type, address, access_bytes, write_data, output ready);
endinterface

// ===== rtl/dcrb_rsp_if.sv =====
`timescale 1ns / 1ps
interface dcrb_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        irq_pulse;
	logic [3:0]  irq_channel;
	logic        xfer_valid;
	logic [31:0] xfer_source;
	logic [31:0] xfer_dest;
	logic [31:0] xfer_bytes;
	logic        src_fixed;
	logic        dst_fixed;
	logic [5:0]  unit_bytes;
	logic        last;

	modport source (output valid, read_data, irq_pulse, irq_channel, xfer_valid, xfer_source,
		xfer_dest, xfer_bytes, src_fixed, dst_fixed, unit_bytes, last, input ready);
	modport sink (input valid, read_data, irq_pulse, irq_channel, xfer_valid, xfer_source,
		xfer_dest, xfer_bytes, src_fixed, dst_fixed, unit_bytes, last, output ready);
endinterface

// ===== rtl/dma_channel_register_bank.sv =====
`timescale 1ns / 1ps
// register bank of a dma controller with up to sixteen channels. one bus access at a time:
// an access is taken on req, decoded and executed in the next cycle, and its result appears
// on rsp the cycle after; a chained start gives a second result (last = 1 on the final one).
// the controller runs the sequence capture, execute, deliver, with a second deliver for a chained
// start. req is ready again once the final result is taken.
module dma_channel_register_bank #(
	parameter int NUM_CHANNELS = dcrb_pkg::NUM_CHANNELS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	dcrb_req_if.sink   req,
	dcrb_rsp_if.source rsp
);
	dcrb_pkg::cmd_t    cmd;
	dcrb_pkg::sts_t    sts;
	dcrb_pkg::result_t result;

	dcrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	dcrb_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.address      (req.address),
		.access_bytes (req.access_bytes),
		.write_data   (req.write_data),
		.sts          (sts),
		.result       (result)
	);

	assign rsp.read_data   = result.read_data;
	assign rsp.irq_pulse   = result.irq_pulse;
	assign rsp.irq_channel = result.irq_channel;
	assign rsp.xfer_valid  = result.xfer_valid;
	assign rsp.xfer_source = result.xfer_source;
	assign rsp.xfer_dest   = result.xfer_dest;
	assign rsp.xfer_bytes  = result.xfer_bytes;
	assign rsp.src_fixed   = result.src_fixed;
	assign rsp.dst_fixed   = result.dst_fixed;
	assign rsp.unit_bytes  = result.unit_bytes;
	assign rsp.last        = result.last;

	// one access in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while result pending");

	// a non-final result is followed by the final one
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.last |=> rsp.valid && rsp.last)
		else $error("second result missing");

	// interrupt rides on the final result only
	a_irq_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.irq_pulse |-> rsp.last) else $error("irq on non-final result");

	// only a chained start splits into two results
	a_split_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.xfer_valid) else $error("split result without copy");
endmodule

// ===== rtl/dcrb_ctrl.sv =====
`timescale 1ns / 1ps
module dcrb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             rsp_ready,
	input  dcrb_pkg::sts_t   sts,
	output logic             req_ready,
	output logic             rsp_valid,
	output dcrb_pkg::cmd_t   cmd
);
	dcrb_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dcrb_pkg::ST_IDLE: begin
				if (req_valid) state_nx = dcrb_pkg::ST_EXEC;
			end
			dcrb_pkg::ST_EXEC: begin
				state_nx = dcrb_pkg::ST_OUT1;
			end
			dcrb_pkg::ST_OUT1: begin
				if (rsp_ready) state_nx = sts.two ? dcrb_pkg::ST_OUT2 : dcrb_pkg::ST_IDLE;
			end
			dcrb_pkg::ST_OUT2: begin
				if (rsp_ready) state_nx = dcrb_pkg::ST_IDLE;
			end
			default: state_nx = dcrb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.sel2    = 1'b0;
		case (state_q)
			dcrb_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			dcrb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			dcrb_pkg::ST_OUT1: begin
				rsp_valid = 1'b1;
			end
			dcrb_pkg::ST_OUT2: begin
				rsp_valid = 1'b1;
				cmd.sel2  = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end
endmodule

// ===== rtl/dcrb_datapath.sv =====
`timescale 1ns / 1ps
module dcrb_datapath #(
	parameter int NUM_CHANNELS = dcrb_pkg::NUM_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dcrb_pkg::cmd_t     cmd,
	input  logic               req_type,
	input  logic [10:0]        address,
	input  logic [2:0]         access_bytes,
	input  logic [31:0]        write_data,
	output dcrb_pkg::sts_t     sts,
	output dcrb_pkg::result_t  result
);
	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam logic [4:0] NCH = 5'(NUM_CHANNELS);

	logic        wr_q;
	logic [10:0] addr_q;
	logic [2:0]  nb_q;
	logic [31:0] wd_q;

	logic [31:0] src0_q [NUM_CHANNELS];
	logic [31:0] dst0_q [NUM_CHANNELS];
	logic [31:0] cnt0_q [NUM_CHANNELS];
	logic [31:0] src1_q [NUM_CHANNELS];
	logic [31:0] dst1_q [NUM_CHANNELS];
	logic [31:0] cnt1_q [NUM_CHANNELS];
	logic [31:0] cur_src_q [NUM_CHANNELS];
	logic [31:0] cur_dst_q [NUM_CHANNELS];
	logic [31:0] cur_cnt_q [NUM_CHANNELS];
	logic [6:0]  status_q [NUM_CHANNELS];
	logic [31:0] config_q [NUM_CHANNELS];
	logic [31:0] intvl_q [NUM_CHANNELS];
	logic [31:0] ext_q [NUM_CHANNELS];
	logic [31:0] link_q [NUM_CHANNELS];
	logic [31:0] cur_link_q [NUM_CHANNELS];
	logic [31:0] gctrl_q [2];

	dcrb_pkg::result_t res1_q, res2_q;
	dcrb_pkg::result_t res1_d, res2_d;
	logic              two_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wr_q   <= req_type;
			addr_q <= address;
			nb_q   <= access_bytes;
			wd_q   <= write_data;
		end
	end

	// access decode
	logic [4:0]      shift;
	logic [31:0]     lanes, mask, val, ctl;
	logic [3:0]      chan_num;
	logic [CH_W-1:0] ch;
	logic            hit, grp;
	logic [3:0]      rg;
	logic [7:0]      gword;

	always_comb begin
		shift    = {addr_q[1:0], 3'b000};
		case (nb_q)
			3'd0:    lanes = 32'h0000_0000;
			3'd1:    lanes = 32'h0000_00ff;
			3'd2:    lanes = 32'h0000_ffff;
			3'd3:    lanes = 32'h00ff_ffff;
			default: lanes = 32'hffff_ffff;
		endcase
		mask     = nb_q[2] ? 32'hffff_ffff : (lanes << shift);
		val      = wd_q << shift;
		ctl      = val & mask;
		chan_num = {addr_q[10], addr_q[8:6]};
		hit      = !addr_q[9] && ({1'b0, chan_num} < NCH);
		ch       = chan_num[CH_W-1:0];
		rg       = addr_q[5:2];
		grp      = addr_q[10];
		gword    = addr_q[9:2];
	end

	// status bits gathered per channel, padded to sixteen
	logic [15:0] en_all, er_all, end_all, tc_all;
	always_comb begin
		en_all  = '0;
		er_all  = '0;
		end_all = '0;
		tc_all  = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			en_all[i]  = |(status_q[i] & dcrb_pkg::ST_EN);
			er_all[i]  = |(status_q[i] & dcrb_pkg::ST_ER);
			end_all[i] = |(status_q[i] & dcrb_pkg::ST_END);
			tc_all[i]  = |(status_q[i] & dcrb_pkg::ST_TC);
		end
	end

	logic [31:0] rd_val;
	always_comb begin
		rd_val = '0;
		if (hit) begin
			case (rg)
				dcrb_pkg::RG_SRC0:   rd_val = src0_q[ch];
				dcrb_pkg::RG_DST0:   rd_val = dst0_q[ch];
				dcrb_pkg::RG_CNT0:   rd_val = cnt0_q[ch];
				dcrb_pkg::RG_SRC1:   rd_val = src1_q[ch];
				dcrb_pkg::RG_DST1:   rd_val = dst1_q[ch];
				dcrb_pkg::RG_CNT1:   rd_val = cnt1_q[ch];
				dcrb_pkg::RG_CURSRC: rd_val = cur_src_q[ch];
				dcrb_pkg::RG_CURDST: rd_val = cur_dst_q[ch];
				dcrb_pkg::RG_CURCNT: rd_val = cur_cnt_q[ch];
				dcrb_pkg::RG_STATUS: rd_val = {25'd0, status_q[ch]};
				dcrb_pkg::RG_CONFIG: rd_val = config_q[ch];
				dcrb_pkg::RG_INTVL:  rd_val = intvl_q[ch];
				dcrb_pkg::RG_EXT:    rd_val = ext_q[ch];
				dcrb_pkg::RG_LINK:   rd_val = link_q[ch];
				dcrb_pkg::RG_CURLNK: rd_val = cur_link_q[ch];
				default:             rd_val = '0;
			endcase
		end else begin
			case (gword)
				dcrb_pkg::GW_CTRL: rd_val = gctrl_q[grp];
				dcrb_pkg::GW_EN:   rd_val = {24'd0, grp ? en_all[15:8] : en_all[7:0]};
				dcrb_pkg::GW_ER:   rd_val = {24'd0, grp ? er_all[15:8] : er_all[7:0]};
				dcrb_pkg::GW_END:  rd_val = {24'd0, grp ? end_all[15:8] : end_all[7:0]};
				dcrb_pkg::GW_TC:   rd_val = {24'd0, grp ? tc_all[15:8] : tc_all[7:0]};
				default:           rd_val = '0;
			endcase
		end
	end

	// control word and start
	logic        ctl_wr, start, chain, dem, sf, df;
	logic [31:0] cfg;
	logic [6:0]  st_new;
	logic [5:0]  unit;
	always_comb begin
		ctl_wr = wr_q && hit && (rg == dcrb_pkg::RG_CTRL);
		cfg    = config_q[ch];
		start  = ctl_wr && ctl[dcrb_pkg::CT_SETEN];
		chain  = cfg[dcrb_pkg::CFG_REN_BIT] && cfg[dcrb_pkg::CFG_RSW_BIT];
		dem    = cfg[dcrb_pkg::CFG_DEM_BIT];
		sf     = cfg[dcrb_pkg::CFG_SAD_BIT];
		df     = cfg[dcrb_pkg::CFG_DAD_BIT];
		unit   = dcrb_pkg::unit_size(cfg);
		st_new = status_q[ch];
		if (ctl[dcrb_pkg::CT_SWRST]) st_new = '0;
		if (ctl[dcrb_pkg::CT_CLREN]) st_new = st_new & ~dcrb_pkg::ST_EN;
		if (ctl[dcrb_pkg::CT_CLREND]) st_new = st_new & ~dcrb_pkg::ST_END;
		if (ctl[dcrb_pkg::CT_CLRTC]) st_new = st_new & ~dcrb_pkg::ST_TC;
		if (start) begin
			st_new = st_new & ~(dcrb_pkg::ST_EN | dcrb_pkg::ST_TACT | dcrb_pkg::ST_ER);
			st_new = st_new | dcrb_pkg::ST_END | dcrb_pkg::ST_TC;
		end
	end

	// the current registers end as after the last command issued
	logic [31:0] fin_sa, fin_da, fin_n;
	always_comb begin
		fin_sa = (start && chain) ? src1_q[ch] : src0_q[ch];
		fin_da = (start && chain) ? dst1_q[ch] : dst0_q[ch];
		fin_n  = (start && chain) ? cnt1_q[ch] : cnt0_q[ch];
	end

	logic plain_wr;
	assign plain_wr = cmd.exec && wr_q && hit && (rg != dcrb_pkg::RG_CTRL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				src0_q[i]     <= '0;
				dst0_q[i]     <= '0;
				cnt0_q[i]     <= '0;
				src1_q[i]     <= '0;
				dst1_q[i]     <= '0;
				cnt1_q[i]     <= '0;
				cur_src_q[i]  <= '0;
				cur_dst_q[i]  <= '0;
				cur_cnt_q[i]  <= '0;
				status_q[i]   <= '0;
				config_q[i]   <= (i == 4) ? dcrb_pkg::CFG_CH4_RESET : '0;
				intvl_q[i]    <= '0;
				ext_q[i]      <= '0;
				link_q[i]     <= '0;
				cur_link_q[i] <= '0;
			end
			gctrl_q[0] <= '0;
			gctrl_q[1] <= '0;
		end else if (cmd.exec && wr_q) begin
			if (plain_wr) begin
				case (rg)
					dcrb_pkg::RG_SRC0:   src0_q[ch] <= (src0_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_DST0:   dst0_q[ch] <= (dst0_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_CNT0:   cnt0_q[ch] <= (cnt0_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_SRC1:   src1_q[ch] <= (src1_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_DST1:   dst1_q[ch] <= (dst1_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_CNT1:   cnt1_q[ch] <= (cnt1_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_CONFIG: config_q[ch] <= (config_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_INTVL:  intvl_q[ch] <= (intvl_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_EXT:    ext_q[ch] <= (ext_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_LINK:   link_q[ch] <= (link_q[ch] & ~mask) | (val & mask);
					dcrb_pkg::RG_CURLNK: cur_link_q[ch] <= (cur_link_q[ch] & ~mask) | (val & mask);
					default: ;
				endcase
			end
			if (ctl_wr) begin
				status_q[ch] <= st_new;
				if (start) begin
					cur_src_q[ch] <= sf ? fin_sa : fin_sa + fin_n;
					cur_dst_q[ch] <= df ? fin_da : fin_da + fin_n;
					cur_cnt_q[ch] <= '0;
				end
			end
			if (!hit && gword == dcrb_pkg::GW_CTRL)
				gctrl_q[grp] <= (gctrl_q[grp] & ~mask) | (val & mask);
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q <= 1'b0;
		end else if (cmd.exec) begin
			two_q <= start && chain;
		end
	end

	always_comb begin
		res1_d           = '0;
		res2_d           = '0;
		res1_d.read_data = wr_q ? 32'd0 : ((rd_val >> shift) & lanes);
		res1_d.last      = !(start && chain);
		res2_d.last      = 1'b1;
		if (start) begin
			res1_d.xfer_valid  = 1'b1;
			res1_d.xfer_source = src0_q[ch];
			res1_d.xfer_dest   = dst0_q[ch];
			res1_d.xfer_bytes  = cnt0_q[ch];
			res1_d.src_fixed   = sf;
			res1_d.dst_fixed   = df;
			res1_d.unit_bytes  = unit;
			res2_d.xfer_valid  = 1'b1;
			res2_d.xfer_source = src1_q[ch];
			res2_d.xfer_dest   = dst1_q[ch];
			res2_d.xfer_bytes  = cnt1_q[ch];
			res2_d.src_fixed   = sf;
			res2_d.dst_fixed   = df;
			res2_d.unit_bytes  = unit;
			if (chain) begin
				res2_d.irq_pulse   = 1'b1;
				res2_d.irq_channel = chan_num;
			end else if (!dem) begin
				res1_d.irq_pulse   = 1'b1;
				res1_d.irq_channel = chan_num;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res1_q <= res1_d;
			res2_q <= res2_d;
		end
	end

	assign sts.two = two_q;
	assign result  = cmd.sel2 ? res2_q : res1_q;
endmodule
